// ===== rtl/v3a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared types, constants and helpers of the three-component vector ALU.
// ----------------------------------------------------------------------------
package v3a_pkg;

   localparam int WORD_W      = 32;
   localparam int OP_W        = 3;
   localparam int REQ_DATA_W  = 232;
   localparam int RSP_DATA_W  = 136;
   localparam int WIDE_W      = 66;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_NEG  = 3'd2,
      OP_SCL  = 3'd3,
      OP_NORM = 3'd4,
      OP_CROSS = 3'd5,
      OP_DOT  = 3'd6,
      OP_MAG  = 3'd7
   } opcode_type;

   typedef struct packed {
      opcode_type                   op;
      logic                         slow;
      logic [2:0][WORD_W-1:0]       a;
      logic [2:0][WORD_W-1:0]       b;
      logic [WORD_W-1:0]            s;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0] val;
      logic              ov;
   } sat_type;

   localparam logic signed [WIDE_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -66'sd2147483648;

   function automatic sat_type sat32(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.val = 32'h7FFF_FFFF;
         r.ov  = 1'b1;
      end else if (v < SAT_LO) begin
         r.val = 32'h8000_0000;
         r.ov  = 1'b1;
      end else begin
         r.val = v[WORD_W-1:0];
         r.ov  = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/v3a_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_front
// Request intake: unpack the request, mark iterative opcodes, hand to queue.
// ----------------------------------------------------------------------------
module v3a_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operation, first_x, first_y, first_z, second_x, second_y, second_z, scalar
   input  logic [v3a_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              push_valid,
   input  logic                              push_ready,
   output v3a_pkg::item_type                 push_item
);

   logic              front_valid_ff, front_valid_in;
   v3a_pkg::item_type front_item_ff, front_item_in;
   logic              take;

   assign req_tready = !front_valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      front_item_in      = front_item_ff;
      front_valid_in     = front_valid_ff;
      if (push_ready) begin
         front_valid_in = 1'b0;
      end
      if (take) begin
         front_valid_in   = 1'b1;
         front_item_in.op = v3a_pkg::opcode_type'(req_tdata[v3a_pkg::OP_W-1:0]);
         for (int i = 0; i < 3; i++) begin
            front_item_in.a[i] =
               req_tdata[v3a_pkg::OP_W + v3a_pkg::WORD_W*i +: v3a_pkg::WORD_W];
            front_item_in.b[i] =
               req_tdata[v3a_pkg::OP_W + v3a_pkg::WORD_W*(i+3) +: v3a_pkg::WORD_W];
         end
         front_item_in.s =
            req_tdata[v3a_pkg::OP_W + v3a_pkg::WORD_W*6 +: v3a_pkg::WORD_W];
         front_item_in.slow = (front_item_in.op == v3a_pkg::OP_NORM) ||
                              (front_item_in.op == v3a_pkg::OP_MAG);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

endmodule

// ===== rtl/v3a_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_queue
// Short first-in first-out queue between intake and execution.
// ----------------------------------------------------------------------------
module v3a_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  v3a_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output v3a_pkg::item_type pop_item
);

   v3a_pkg::item_type                 mem_ff [v3a_pkg::QUEUE_DEPTH];
   logic [v3a_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [v3a_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [v3a_pkg::QPTR_W:0]          count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_ready = count_ff != (v3a_pkg::QPTR_W+1)'(v3a_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/v3a_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_back
// Execution: product stage, root and divide sequencer, saturation, output.
// ----------------------------------------------------------------------------
module v3a_back #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  v3a_pkg::item_type                 pop_item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [v3a_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int W  = v3a_pkg::WIDE_W;
   localparam int RS = 32;
   localparam int DS = 64;
   localparam int CNT_W = $clog2(DS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ROOT = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } seq_state_type;

   logic                 a_valid_ff, a_valid_in;
   v3a_pkg::item_type    a_item_ff, a_item_in;
   logic signed [31:0]   mul_a [6];
   logic signed [31:0]   mul_b [6];
   logic signed [63:0]   prod_ff [6];
   logic signed [63:0]   prod_in [6];

   seq_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [63:0]          rad_ff, rad_in;
   logic [33:0]          rem_ff, rem_in, rem_step;
   logic [31:0]          root_ff, root_in, root_step;
   logic [35:0]          rem_t, trial;
   logic [63:0]          dq_ff [3];
   logic [63:0]          dq_in [3];
   logic [63:0]          dq_step [3];
   logic [31:0]          drem_ff [3];
   logic [31:0]          drem_in [3];
   logic [31:0]          drem_step [3];
   logic [32:0]          div_t [3];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          res_ff [4];
   logic [31:0]          res_in [4];
   logic                 ov_ff, ov_in;

   logic                 a_done, out_free, out_load, a_free, a_load;
   logic signed [W-1:0]  wide [4];
   logic signed [W-1:0]  a_w [3];
   logic signed [W-1:0]  b_w [3];
   logic signed [W-1:0]  p_w [6];
   logic [W-1:0]         q_mag [3];
   logic signed [W-1:0]  norm_val [3];
   v3a_pkg::sat_type     sat [4];

   assign a_done    = a_valid_ff && (!a_item_ff.slow || state_ff == ST_DONE);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign out_load  = a_done && out_free;
   assign a_free    = !a_valid_ff || out_load;
   assign a_load    = pop_valid && a_free;
   assign pop_ready = a_free;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         mul_a[k] = '0;
         mul_b[k] = '0;
      end
      unique case (pop_item.op)
         v3a_pkg::OP_SCL: begin
            for (int k = 0; k < 3; k++) begin
               mul_a[k] = $signed(pop_item.a[k]);
               mul_b[k] = $signed(pop_item.s);
            end
         end
         v3a_pkg::OP_CROSS: begin
            mul_a[0] = $signed(pop_item.a[1]); mul_b[0] = $signed(pop_item.b[2]);
            mul_a[1] = $signed(pop_item.a[2]); mul_b[1] = $signed(pop_item.b[1]);
            mul_a[2] = $signed(pop_item.a[2]); mul_b[2] = $signed(pop_item.b[0]);
            mul_a[3] = $signed(pop_item.a[0]); mul_b[3] = $signed(pop_item.b[2]);
            mul_a[4] = $signed(pop_item.a[0]); mul_b[4] = $signed(pop_item.b[1]);
            mul_a[5] = $signed(pop_item.a[1]); mul_b[5] = $signed(pop_item.b[0]);
         end
         v3a_pkg::OP_DOT: begin
            for (int k = 0; k < 3; k++) begin
               mul_a[k] = $signed(pop_item.a[k]);
               mul_b[k] = $signed(pop_item.b[k]);
            end
         end
         v3a_pkg::OP_NORM: begin
            for (int k = 0; k < 3; k++) begin
               mul_a[k]   = $signed(pop_item.b[k]);
               mul_b[k]   = $signed(pop_item.b[k]);
               mul_a[k+3] = $signed(pop_item.b[k]);
               mul_b[k+3] = $signed(pop_item.s);
            end
         end
         v3a_pkg::OP_MAG: begin
            for (int k = 0; k < 3; k++) begin
               mul_a[k] = $signed(pop_item.a[k]);
               mul_b[k] = $signed(pop_item.a[k]);
            end
         end
         v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_NEG: begin
         end
      endcase
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = a_load ? 64'(mul_a[k] * mul_b[k]) : prod_ff[k];
      end
      a_item_in  = a_load ? pop_item : a_item_ff;
      a_valid_in = a_load ? 1'b1 : (out_load ? 1'b0 : a_valid_ff);
   end

   always_comb begin
      rem_t = {rem_ff, rad_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      if (rem_t >= trial) begin
         rem_step  = 34'(rem_t - trial);
         root_step = {root_ff[30:0], 1'b1};
      end else begin
         rem_step  = rem_t[33:0];
         root_step = {root_ff[30:0], 1'b0};
      end
      for (int i = 0; i < 3; i++) begin
         div_t[i] = {drem_ff[i], dq_ff[i][63]};
         if (div_t[i] >= {1'b0, root_ff}) begin
            drem_step[i] = 32'(div_t[i] - {1'b0, root_ff});
            dq_step[i]   = {dq_ff[i][62:0], 1'b1};
         end else begin
            drem_step[i] = div_t[i][31:0];
            dq_step[i]   = {dq_ff[i][62:0], 1'b0};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      for (int i = 0; i < 3; i++) begin
         dq_in[i]   = dq_ff[i];
         drem_in[i] = drem_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (a_valid_ff && a_item_ff.slow) begin
               rad_in   = prod_ff[0] + prod_ff[1] + prod_ff[2];
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[61:0], 2'b00};
            rem_in  = rem_step;
            root_in = root_step;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RS - 1)) begin
               if (a_item_ff.op == v3a_pkg::OP_NORM && root_step != '0) begin
                  for (int i = 0; i < 3; i++) begin
                     dq_in[i]   = prod_ff[i+3][63] ? 64'(-prod_ff[i+3]) : prod_ff[i+3];
                     drem_in[i] = '0;
                  end
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            for (int i = 0; i < 3; i++) begin
               dq_in[i]   = dq_step[i];
               drem_in[i] = drem_step[i];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_w[i]      = W'($signed(a_item_ff.a[i]));
         b_w[i]      = W'($signed(a_item_ff.b[i]));
         q_mag[i]    = {2'b00, dq_ff[i]} + {{(W-1){1'b0}}, |drem_ff[i]};
         norm_val[i] = prod_ff[i+3][63] ? -$signed(q_mag[i]) : $signed({2'b00, dq_ff[i]});
      end
      for (int k = 0; k < 6; k++) begin
         p_w[k] = W'(prod_ff[k]);
      end
      for (int i = 0; i < 4; i++) begin
         wide[i] = '0;
      end
      unique case (a_item_ff.op)
         v3a_pkg::OP_ADD: begin
            for (int i = 0; i < 3; i++) wide[i] = a_w[i] + b_w[i];
         end
         v3a_pkg::OP_SUB: begin
            for (int i = 0; i < 3; i++) wide[i] = a_w[i] - b_w[i];
         end
         v3a_pkg::OP_NEG: begin
            for (int i = 0; i < 3; i++) wide[i] = -a_w[i];
         end
         v3a_pkg::OP_SCL: begin
            for (int i = 0; i < 3; i++) wide[i] = p_w[i] >>> FRACTION_BITS;
         end
         v3a_pkg::OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               wide[i] = (root_ff == '0) ? b_w[i] : norm_val[i];
            end
         end
         v3a_pkg::OP_CROSS: begin
            wide[0] = (p_w[0] - p_w[1]) >>> FRACTION_BITS;
            wide[1] = (p_w[2] - p_w[3]) >>> FRACTION_BITS;
            wide[2] = (p_w[4] - p_w[5]) >>> FRACTION_BITS;
         end
         v3a_pkg::OP_DOT: begin
            wide[3] = (p_w[0] + p_w[1] + p_w[2]) >>> FRACTION_BITS;
         end
         v3a_pkg::OP_MAG: begin
            wide[3] = $signed({{(W-32){1'b0}}, root_ff});
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         sat[i]    = v3a_pkg::sat32(wide[i]);
         res_in[i] = out_load ? sat[i].val : res_ff[i];
      end
      ov_in        = out_load ? (sat[0].ov | sat[1].ov | sat[2].ov | sat[3].ov) : ov_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
      end
      a_item_ff <= a_item_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      ov_ff     <= ov_in;
      for (int k = 0; k < 6; k++) prod_ff[k] <= prod_in[k];
      for (int i = 0; i < 3; i++) begin
         dq_ff[i]   <= dq_in[i];
         drem_ff[i] <= drem_in[i];
      end
      for (int i = 0; i < 4; i++) res_ff[i] <= res_in[i];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, ov_ff, res_ff[3], res_ff[2], res_ff[1], res_ff[0]};

   a_slow_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_item_ff.slow && state_ff != ST_DONE |-> !out_load)
      else $error("iterative request left before its sequence finished");

   a_seq_owner: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> a_valid_ff && a_item_ff.slow)
      else $error("sequencer busy without an iterative request in place");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> root_ff != '0)
      else $error("divide started with a zero magnitude");

   a_done_leaves: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_load |=> state_ff == ST_IDLE)
      else $error("sequencer did not release after the result left");

endmodule

// ===== rtl/vector3_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component vector ALU in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Add, subtract, negate, scale, cross and dot take one request per clock while
// rsp_tready is high and no magnitude or normalize request holds the execution
// stage. A response passes through the intake register, the queue entry, the
// product register and the output register. Magnitude and normalize go through
// a shared bit-serial square root and, for normalize with a nonzero magnitude,
// three bit-serial dividers running side by side; while these run the request
// occupies the execution stage, and later requests queue behind it in order.
module vector3_alu #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operation, first_x, first_y, first_z, second_x, second_y, second_z, scalar
   input  logic [v3a_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_x, result_y, result_z, scalar_result, overflow
   output logic [v3a_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic              push_valid, push_ready, pop_valid, pop_ready;
   v3a_pkg::item_type push_item, pop_item;

   v3a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   v3a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   v3a_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
